### rtl/core/slcd_pkg.sv
`default_nettype none

package slcd_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;

	typedef enum logic [6:0] {
		PH_HUNT   = 7'b000_0001,
		PH_TYPE   = 7'b000_0010,
		PH_LEN_HI = 7'b000_0100,
		PH_LEN_LO = 7'b000_1000,
		PH_DATA   = 7'b001_0000,
		PH_CK_HI  = 7'b010_0000,
		PH_CK_LO  = 7'b100_0000
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_END     = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		logic        frame_ok;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/slcd_rx_if.sv
`default_nettype none

interface slcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/slcd_res_if.sv
`default_nettype none

interface slcd_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_type;
	logic [15:0] frame_length;
	logic        frame_ok;

	modport source (
		output valid, output result_kind, output payload_byte,
		output frame_type, output frame_length, output frame_ok,
		input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte,
		input frame_type, input frame_length, input frame_ok,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/slcd_parser.sv
`default_nettype none

module slcd_parser
	import slcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	output res_t            res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] length_q, length_d;
	logic [15:0] left_q, left_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  ck_hi_q, ck_hi_d;
	logic [15:0] sum_add;
	logic [15:0] len_full;

	assign sum_add  = sum_q + {8'h00, rx_byte};
	assign len_full = {length_q[15:8], rx_byte};

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		length_d  = length_q;
		left_d    = left_q;
		sum_d     = sum_q;
		ck_hi_d   = ck_hi_q;
		res_valid = 1'b0;
		res.result_kind  = KIND_PAYLOAD;
		res.payload_byte = 8'h00;
		res.frame_type   = type_q;
		res.frame_length = length_q;
		res.frame_ok     = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_TYPE: begin
					type_d  = rx_byte;
					sum_d   = sum_add;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					length_d = {rx_byte, 8'h00};
					sum_d    = sum_add;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_d = len_full;
					left_d   = len_full;
					sum_d    = sum_add;
					phase_d  = (len_full == 16'h0000) ? PH_CK_HI : PH_DATA;
				end
				PH_DATA: begin
					sum_d  = sum_add;
					left_d = left_q - 16'h0001;
					if (left_q == 16'h0001) begin
						phase_d = PH_CK_HI;
					end
					res_valid        = 1'b1;
					res.payload_byte = rx_byte;
				end
				PH_CK_HI: begin
					ck_hi_d = rx_byte;
					phase_d = PH_CK_LO;
				end
				PH_CK_LO: begin
					res_valid       = 1'b1;
					res.result_kind = KIND_END;
					res.frame_ok    = ({ck_hi_q, rx_byte} == sum_q);
					phase_d         = PH_HUNT;
				end
				default: begin
					phase_d = PH_HUNT;
					if (rx_byte == SYNC_BYTE) begin
						sum_d   = {8'h00, SYNC_BYTE};
						phase_d = PH_TYPE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			type_q   <= '0;
			length_q <= '0;
			left_q   <= '0;
			sum_q    <= '0;
			ck_hi_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			left_q   <= left_d;
			sum_q    <= sum_d;
			ck_hi_q  <= ck_hi_d;
		end
	end

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != 16'h0000))
		else $error("payload phase with no bytes left");

	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind == KIND_END) |=> (phase_q == PH_HUNT))
		else $error("frame end did not return to hunting");

	a_res_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> accept)
		else $error("result without an accepted word");

endmodule

`default_nettype wire

### rtl/core/slcd_out_buf.sv
`default_nettype none

module slcd_out_buf
	import slcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire res_t in_data,
	output logic      in_ready,
	output logic      out_valid,
	output res_t      out_data,
	input  wire logic out_ready
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic main_free;

	assign main_free = !main_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid word held with empty output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !in_valid)
		else $error("word pushed into full buffer");

	a_stall_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		(main_valid_q && !out_ready) |=> (main_valid_q && $stable(main_q)))
		else $error("stalled output word lost or changed");

endmodule

`default_nettype wire

### rtl/core/sync_length_checksum_deframer.sv
// Sync/type/length deframer with a 16-bit additive checksum. Takes one byte per
// clock on rx while ready, hunts for 0xAA, then reads type, big-endian length,
// payload and big-endian checksum; each payload byte comes out on res as a
// payload word and the last checksum byte gives one end word carrying type,
// length and frame_ok. A byte is handled in the cycle it is accepted, so one
// byte per cycle is sustained while rx is ready; results are registered before
// they reach res. A two-word output register with skid keeps rx ready while
// a result waits; rx drops ready only with a second result behind a stalled one.
`default_nettype none

module sync_length_checksum_deframer
	import slcd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	slcd_rx_if.sink  rx,
	slcd_res_if.source res
);

	logic accept;
	logic buf_ready;
	logic res_valid;
	res_t res_word;
	res_t out_word;

	assign rx.ready = buf_ready;
	assign accept   = rx.valid && buf_ready;

	slcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx.rx_byte),
		.res_valid (res_valid),
		.res       (res_word)
	);

	slcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res_word),
		.in_ready  (buf_ready),
		.out_valid (res.valid),
		.out_data  (out_word),
		.out_ready (res.ready)
	);

	assign res.result_kind  = out_word.result_kind;
	assign res.payload_byte = out_word.payload_byte;
	assign res.frame_type   = out_word.frame_type;
	assign res.frame_length = out_word.frame_length;
	assign res.frame_ok     = out_word.frame_ok;

endmodule

`default_nettype wire
